// File: hdl/posd_pkg.sv
// Shared types, widths and helper functions for the point-on-segment block.
// Used by every module of the block; depends on nothing.
`default_nettype none

package posd_pkg;

  localparam int CW   = 16;                      // coordinate bits
  localparam int DW   = 24;                      // distance bits
  localparam int FW   = 8;                       // distance fraction bits
  localparam int PW   = DW + CW;                 // distance * |delta|
  localparam int HW   = PW / 2;                  // half of that product
  localparam int SQW  = 2 * PW;                  // its square
  localparam int SW   = 2 * CW + 1;              // squared length
  localparam int KW   = SW + 2 * FW;             // squared length, scaled
  localparam int NW   = (DW > FW) ? DW - FW : 1; // integer offset bits
  localparam int PPW  = NW + KW;                 // offset * scaled length
  localparam int TW   = 2 * NW + KW + 1;         // trial term
  localparam int EW   = ((CW > NW) ? CW : NW) + 2;
  localparam int IN_W = 4 * CW + DW;
  localparam int OUT_W = ((2 * CW + 2 + 7) / 8) * 8;
  localparam int QD   = 4;                       // queue depth
  localparam int QAW  = $clog2(QD);

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic [CW-1:0]        adx;
    logic [CW-1:0]        ady;
    logic                 negx;
    logic                 negy;
    logic                 degen;
    logic [DW-1:0]        distance;
  } item_t;

  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic                 negx;
    logic                 negy;
    logic                 degen;
    logic [KW-1:0]        k;
    logic [SQW-1:0]       rx;
    logic [SQW-1:0]       ry;
    logic [PPW-1:0]       px;
    logic [PPW-1:0]       py;
    logic [NW-1:0]        nx;
    logic [NW-1:0]        ny;
  } rec_t;

  typedef struct packed {
    logic signed [CW-1:0] val;
    logic                 sat;
  } coord_t;

  // Term added to the squared offset times the scaled length when bit b is set.
  function automatic logic [TW-1:0] trial(input logic [PPW-1:0] p,
                                          input logic [KW-1:0] k, input int b);
    logic [TW-1:0] pe;
    logic [TW-1:0] ke;
    pe = TW'(p);
    ke = TW'(k);
    return (pe << (b + 1)) + (ke << (2 * b));
  endfunction

  // Truncate start +/- (n + fraction) toward zero, then clamp.
  function automatic coord_t place(input logic signed [CW-1:0] s, input logic neg,
                                   input logic [NW-1:0] n, input logic exact);
    logic signed [EW-1:0] se;
    logic signed [EW-1:0] ne;
    logic signed [EW-1:0] b;
    logic signed [EW-1:0] r;
    coord_t               c;
    se = EW'(s);
    ne = $signed(EW'(n));
    if (!neg) begin
      b = se + ne;
      r = (b >= 0 || exact) ? b : b + EW'(1);
    end else begin
      b = se - ne;
      r = (b <= 0 || exact) ? b : b - EW'(1);
    end
    c.sat = 1'b0;
    if (r > EW'(COORD_MAX)) begin
      c.val = COORD_MAX;
      c.sat = 1'b1;
    end else if (r < EW'(COORD_MIN)) begin
      c.val = COORD_MIN;
      c.sat = 1'b1;
    end else begin
      c.val = r[CW-1:0];
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hdl/posd_front.sv
// Front stage: accept a point request, form deltas, magnitudes and signs.
// Depends on posd_pkg.
`default_nettype none

module posd_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output      logic                      in_ready_o,
  input  wire logic [posd_pkg::IN_W-1:0] in_data_i,
  output      logic                      out_valid_o,
  input  wire logic                      out_ready_i,
  output      posd_pkg::item_t           out_item_o
);

  localparam int CW = posd_pkg::CW;

  logic                 vld_q;
  posd_pkg::item_t      item_q, item_d;
  logic signed [CW-1:0] sx, sy, ex, ey;
  logic signed [CW:0]   dx, dy;
  logic [CW:0]          adx, ady;

  assign sx = in_data_i[CW-1:0];
  assign sy = in_data_i[2*CW-1:CW];
  assign ex = in_data_i[3*CW-1:2*CW];
  assign ey = in_data_i[4*CW-1:3*CW];
  assign dx = (CW+1)'(ex) - (CW+1)'(sx);
  assign dy = (CW+1)'(ey) - (CW+1)'(sy);
  assign adx = dx[CW] ? -dx : dx;
  assign ady = dy[CW] ? -dy : dy;

  always_comb begin
    item_d.sx       = sx;
    item_d.sy       = sy;
    item_d.adx      = adx[CW-1:0];
    item_d.ady      = ady[CW-1:0];
    item_d.negx     = dx[CW];
    item_d.negy     = dy[CW];
    item_d.degen    = (adx == '0) && (ady == '0);
    item_d.distance = in_data_i[posd_pkg::IN_W-1:4*CW];
  end

  assign in_ready_o  = !vld_q || out_ready_i;
  assign out_valid_o = vld_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/posd_queue.sv
// Short request queue between the front stage and the compute pipeline.
// Depends on posd_pkg.
`default_nettype none

module posd_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire posd_pkg::item_t push_item_i,
  output      logic            full_o,
  input  wire logic            pop_i,
  output      logic            empty_o,
  output      posd_pkg::item_t pop_item_o
);

  localparam int QAW = posd_pkg::QAW;

  posd_pkg::item_t mem_q [posd_pkg::QD];
  logic [QAW-1:0]  wr_q, rd_q;
  logic [QAW:0]    cnt_q;

  assign full_o     = (cnt_q == (QAW+1)'(posd_pkg::QD));
  assign empty_o    = (cnt_q == '0);
  assign pop_item_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QAW+1)'(push_i) - (QAW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_item_i;
  end

endmodule

`default_nettype wire

// File: hdl/posd_back.sv
// Compute pipeline: products, squares, bit-per-stage offset search, placement.
// Depends on posd_pkg.
`default_nettype none

module posd_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output      logic                       in_ready_o,
  input  wire posd_pkg::item_t            in_item_i,
  output      logic                       out_valid_o,
  input  wire logic                       out_ready_i,
  output      logic [posd_pkg::OUT_W-1:0] out_data_o
);

  localparam int CW  = posd_pkg::CW;
  localparam int PW  = posd_pkg::PW;
  localparam int HW  = posd_pkg::HW;
  localparam int SQW = posd_pkg::SQW;
  localparam int KW  = posd_pkg::KW;
  localparam int NW  = posd_pkg::NW;
  localparam int PPW = posd_pkg::PPW;
  localparam int TW  = posd_pkg::TW;
  localparam int FW  = posd_pkg::FW;

  logic en;

  // stage 1: squares of the deltas and distance products
  logic                 v1_q;
  logic signed [CW-1:0] sx1_q, sy1_q;
  logic                 nx1_q, ny1_q, dg1_q;
  logic [2*CW-1:0]      sqx1_q, sqy1_q;
  logic [PW-1:0]        ax1_q, ay1_q;

  // stage 2: scaled length and partial squares
  logic                 v2_q;
  logic signed [CW-1:0] sx2_q, sy2_q;
  logic                 nx2_q, ny2_q, dg2_q;
  logic [KW-1:0]        k2_q;
  logic [2*HW-1:0]      xhh_q, xhl_q, xll_q, yhh_q, yhl_q, yll_q;

  // recurrence stages
  logic                 vr_q [NW+1];
  posd_pkg::rec_t       rec_q [NW+1];

  // output register
  logic                 vo_q;
  logic [posd_pkg::OUT_W-1:0] out_q;

  assign en          = !vo_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      vo_q <= vr_q[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx1_q  <= in_item_i.sx;
      sy1_q  <= in_item_i.sy;
      nx1_q  <= in_item_i.negx;
      ny1_q  <= in_item_i.negy;
      dg1_q  <= in_item_i.degen;
      sqx1_q <= (2*CW)'(in_item_i.adx) * (2*CW)'(in_item_i.adx);
      sqy1_q <= (2*CW)'(in_item_i.ady) * (2*CW)'(in_item_i.ady);
      ax1_q  <= PW'(in_item_i.distance) * PW'(in_item_i.adx);
      ay1_q  <= PW'(in_item_i.distance) * PW'(in_item_i.ady);

      sx2_q <= sx1_q;
      sy2_q <= sy1_q;
      nx2_q <= nx1_q;
      ny2_q <= ny1_q;
      dg2_q <= dg1_q;
      k2_q  <= (KW'(sqx1_q) + KW'(sqy1_q)) << (2 * FW);
      xhh_q <= (2*HW)'(ax1_q[PW-1:HW]) * (2*HW)'(ax1_q[PW-1:HW]);
      xhl_q <= (2*HW)'(ax1_q[PW-1:HW]) * (2*HW)'(ax1_q[HW-1:0]);
      xll_q <= (2*HW)'(ax1_q[HW-1:0])  * (2*HW)'(ax1_q[HW-1:0]);
      yhh_q <= (2*HW)'(ay1_q[PW-1:HW]) * (2*HW)'(ay1_q[PW-1:HW]);
      yhl_q <= (2*HW)'(ay1_q[PW-1:HW]) * (2*HW)'(ay1_q[HW-1:0]);
      yll_q <= (2*HW)'(ay1_q[HW-1:0])  * (2*HW)'(ay1_q[HW-1:0]);
    end
  end

  // stage 3: assemble the squared products, seed the search
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q[0] <= 1'b0;
    end else if (en) begin
      vr_q[0] <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rec_q[0].sx    <= sx2_q;
      rec_q[0].sy    <= sy2_q;
      rec_q[0].negx  <= nx2_q;
      rec_q[0].negy  <= ny2_q;
      rec_q[0].degen <= dg2_q;
      rec_q[0].k     <= k2_q;
      rec_q[0].rx    <= (SQW'(xhh_q) << (2 * HW)) + (SQW'(xhl_q) << (HW + 1)) + SQW'(xll_q);
      rec_q[0].ry    <= (SQW'(yhh_q) << (2 * HW)) + (SQW'(yhl_q) << (HW + 1)) + SQW'(yll_q);
      rec_q[0].px    <= '0;
      rec_q[0].py    <= '0;
      rec_q[0].nx    <= '0;
      rec_q[0].ny    <= '0;
    end
  end

  // one offset bit per stage, most significant first
  for (genvar i = 0; i < NW; i++) begin : g_rec
    localparam int B = NW - 1 - i;
    posd_pkg::rec_t rec_d;
    logic [TW-1:0]  tx, ty;

    always_comb begin
      rec_d = rec_q[i];
      tx = posd_pkg::trial(rec_q[i].px, rec_q[i].k, B);
      ty = posd_pkg::trial(rec_q[i].py, rec_q[i].k, B);
      if (tx <= TW'(rec_q[i].rx)) begin
        rec_d.rx    = rec_q[i].rx - tx[SQW-1:0];
        rec_d.px    = rec_q[i].px + (PPW'(rec_q[i].k) << B);
        rec_d.nx[B] = 1'b1;
      end
      if (ty <= TW'(rec_q[i].ry)) begin
        rec_d.ry    = rec_q[i].ry - ty[SQW-1:0];
        rec_d.py    = rec_q[i].py + (PPW'(rec_q[i].k) << B);
        rec_d.ny[B] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vr_q[i+1] <= 1'b0;
      end else if (en) begin
        vr_q[i+1] <= vr_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) rec_q[i+1] <= rec_d;
    end
  end

  // placement, clamp and status
  posd_pkg::coord_t cx, cy;
  logic [1:0]       st;
  logic signed [CW-1:0] ox, oy;

  always_comb begin
    cx = posd_pkg::place(rec_q[NW].sx, rec_q[NW].negx, rec_q[NW].nx, rec_q[NW].rx == '0);
    cy = posd_pkg::place(rec_q[NW].sy, rec_q[NW].negy, rec_q[NW].ny, rec_q[NW].ry == '0);
    if (rec_q[NW].degen) begin
      ox = rec_q[NW].sx;
      oy = rec_q[NW].sy;
      st = posd_pkg::ST_DEGEN;
    end else begin
      ox = cx.val;
      oy = cy.val;
      st = (cx.sat || cy.sat) ? posd_pkg::ST_SAT : posd_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= posd_pkg::OUT_W'({st, oy, ox});
  end

endmodule

`default_nettype wire

// File: hdl/point_on_segment_at_distance.sv
// Top level of the point-on-segment-at-distance block.
// Instantiates posd_front, posd_queue and posd_back; uses posd_pkg.
//
//   channel  dir  width  payload (lowest bits first)
//   s_axis   in   88     start_x, start_y, end_x, end_y, distance
//   m_axis   out  40     point_x, point_y, status, zero pad
//
// One request per cycle is taken and one result per cycle is given when
// neither side stalls. A result passes through the front register, the
// queue write, two product stages, the seed stage, one stage per offset bit
// of the distance search, and the output register. rst_ni clears all valid
// state asynchronously. A stalled output freezes the compute pipeline; the
// queue and front register then fill before s_axis_tready drops.
`default_nettype none

module point_on_segment_at_distance (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output      logic                       s_axis_tready,
  // start_x, start_y, end_x, end_y, distance
  input  wire logic [posd_pkg::IN_W-1:0]  s_axis_tdata,
  output      logic                       m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // point_x, point_y, status, zero pad
  output      logic [posd_pkg::OUT_W-1:0] m_axis_tdata
);

  logic            fr_valid, fr_ready;
  posd_pkg::item_t fr_item, q_item;
  logic            q_full, q_empty, q_pop, bk_ready;

  // Classify the request: deltas, magnitudes, directions, degenerate flag.
  posd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_item_o  (fr_item)
  );

  // Hold requests so front and compute stall independently.
  assign fr_ready = !q_full;
  assign q_pop    = !q_empty && bk_ready;

  posd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fr_valid && !q_full),
    .push_item_i (fr_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_item_o  (q_item)
  );

  // Compute the offset exactly and place the point.
  posd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_pop),
    .in_ready_o  (bk_ready),
    .in_item_i   (q_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// File: hdl/posd_checker.sv
// Port-level checks for point_on_segment_at_distance, bound to the top level.
// Depends on posd_pkg.
`default_nettype none

module posd_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       m_axis_tvalid,
  input wire logic                       m_axis_tready,
  input wire logic [posd_pkg::OUT_W-1:0] m_axis_tdata
);

  localparam int CW = posd_pkg::CW;

  logic [1:0]           st;
  logic signed [CW-1:0] px, py;

  assign px = m_axis_tdata[CW-1:0];
  assign py = m_axis_tdata[2*CW-1:CW];
  assign st = m_axis_tdata[2*CW+1:2*CW];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (st == posd_pkg::ST_OK || st == posd_pkg::ST_DEGEN ||
                       st == posd_pkg::ST_SAT))
    else $error("undefined status code");

  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st == posd_pkg::ST_SAT |->
      (px == posd_pkg::COORD_MAX || px == posd_pkg::COORD_MIN ||
       py == posd_pkg::COORD_MAX || py == posd_pkg::COORD_MIN))
    else $error("saturated status without a clamped coordinate");

  a_rst: assert property (@(posedge clk_i) $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind point_on_segment_at_distance posd_checker u_posd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: dv/point_on_segment_at_distance_test.sv
// Self-checking testbench for point_on_segment_at_distance: directed and random point requests.
// It predicts each result with exact integer math, with no rounding of length or ratio.
// Depends on posd_pkg and the RTL top level only.
`default_nettype none

module point_on_segment_at_distance_test;
  timeunit 1ns;
  timeprecision 1ps;

  import posd_pkg::*;

  typedef struct {
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic [1:0]           status;
  } point_res_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // start_x, start_y, end_x, end_y, distance
  logic [IN_W-1:0]     s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // point_x, point_y, status, zero pad
  logic [OUT_W-1:0]    m_axis_tdata;

  point_res_t          pending_points[$];
  int                  error_count = 0;
  int                  result_count = 0;
  int                  request_count = 0;
  int                  sat_count = 0;
  int                  degen_count = 0;
  int                  idle_pct = 0;
  int                  stall_pct = 0;

  always #4 clk_i = ~clk_i;

  point_on_segment_at_distance u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Find the largest n with (n * 2^FW)^2 * len2 <= (d * ad)^2; flag equality as exact.
  function automatic longint floor_offset(input longint d, input longint ad,
                                          input longint len2, output bit exact);
    logic [127:0] lhs;
    logic [127:0] rhs;
    logic [127:0] c;
    longint       n;
    longint       cand;
    rhs = 128'(d) * 128'(ad);
    rhs = rhs * rhs;
    n = 0;
    for (int b = DW - 1; b >= 0; b--) begin
      cand = n | (longint'(1) << b);
      if (cand <= (d >> FW)) begin
        c = 128'(cand) << FW;
        lhs = c * c * 128'(len2);
        if (lhs <= rhs) n = cand;
      end
    end
    c = 128'(n) << FW;
    exact = ((c * c * 128'(len2)) == rhs);
    return n;
  endfunction

  // Step from the start by the offset, truncating the true coordinate toward zero.
  function automatic longint step_coord(input longint s, input bit neg, input longint n,
                                        input bit exact);
    longint b;
    if (!neg) begin
      b = s + n;
      return (b >= 0 || exact) ? b : b + 1;
    end
    b = s - n;
    return (b <= 0 || exact) ? b : b - 1;
  endfunction

  function automatic logic signed [CW-1:0] clamp_coord(input longint v, inout bit sat);
    if (v > longint'(COORD_MAX)) begin
      sat = 1'b1;
      return COORD_MAX;
    end
    if (v < longint'(COORD_MIN)) begin
      sat = 1'b1;
      return COORD_MIN;
    end
    return v[CW-1:0];
  endfunction

  function automatic point_res_t predict_point(input logic signed [CW-1:0] sx,
                                               input logic signed [CW-1:0] sy,
                                               input logic signed [CW-1:0] ex,
                                               input logic signed [CW-1:0] ey,
                                               input logic [DW-1:0] distance);
    point_res_t r;
    longint     dx;
    longint     dy;
    longint     adx;
    longint     ady;
    longint     nx;
    longint     ny;
    bit         exx;
    bit         exy;
    bit         sat;
    dx = longint'(ex) - longint'(sx);
    dy = longint'(ey) - longint'(sy);
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    sat = 1'b0;
    if (adx == 0 && ady == 0) begin
      r.px = sx;
      r.py = sy;
      r.status = ST_DEGEN;
    end else begin
      nx = floor_offset(longint'(distance), adx, adx * adx + ady * ady, exx);
      ny = floor_offset(longint'(distance), ady, adx * adx + ady * ady, exy);
      r.px = clamp_coord(step_coord(longint'(sx), dx < 0, nx, exx), sat);
      r.py = clamp_coord(step_coord(longint'(sy), dy < 0, ny, exy), sat);
      r.status = sat ? ST_SAT : ST_OK;
    end
    return r;
  endfunction

  // Present one request from a falling edge; hold tvalid high afterward so
  // back-to-back requests never toggle it within one step.
  task automatic send_point(input logic signed [CW-1:0] sx, input logic signed [CW-1:0] sy,
                            input logic signed [CW-1:0] ex, input logic signed [CW-1:0] ey,
                            input logic [DW-1:0] distance);
    point_res_t r;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {distance, ey, ex, sy, sx};
    do @(posedge clk_i); while (!s_axis_tready);
    r = predict_point(sx, sy, ex, ey, distance);
    pending_points.push_back(r);
    request_count++;
    if (r.status == ST_SAT) sat_count++;
    if (r.status == ST_DEGEN) degen_count++;
    @(negedge clk_i);
  endtask

  // Randomize the receiver stall at each falling edge.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    point_res_t exp_pt;
    logic signed [CW-1:0] got_x;
    logic signed [CW-1:0] got_y;
    logic [1:0] got_st;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_x = m_axis_tdata[CW-1:0];
      got_y = m_axis_tdata[2*CW-1:CW];
      got_st = m_axis_tdata[2*CW+1:2*CW];
      result_count++;
      if (pending_points.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result x=%0d y=%0d status=%0d", $time, got_x, got_y, got_st);
      end else begin
        exp_pt = pending_points.pop_front();
        if (got_x !== exp_pt.px) begin
          error_count++;
          $display("%0t: point_x expected %0d actual %0d", $time, exp_pt.px, got_x);
        end
        if (got_y !== exp_pt.py) begin
          error_count++;
          $display("%0t: point_y expected %0d actual %0d", $time, exp_pt.py, got_y);
        end
        if (got_st !== exp_pt.status) begin
          error_count++;
          $display("%0t: status expected %0d actual %0d", $time, exp_pt.status, got_st);
        end
      end
    end
  end

  // Extremes of every field, coinciding points, saturation, exact and inexact ratios.
  task automatic test_directed();
    send_point(16'sd0, 16'sd0, 16'sd3, 16'sd4, 24'd5 << FW);
    send_point(16'sd0, 16'sd0, 16'sd3, 16'sd4, 24'd0);
    send_point(16'sd0, 16'sd0, 16'sd3, 16'sd4, 24'hFFFFFF);
    send_point(16'sd10, -16'sd7, 16'sd10, -16'sd7, 24'hFFFFFF);
    send_point(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 24'd0);
    send_point(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 24'hFFFFFF);
    send_point(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 24'hFFFFFF);
    send_point(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 24'd1);
    send_point(16'sd32767, 16'sd0, 16'sd32767, 16'sd1, 24'h800000);
    send_point(16'sd0, 16'sd0, -16'sd1, 16'sd0, 24'd383);
    send_point(16'sd0, 16'sd0, 16'sd1, 16'sd1, 24'd256);
    send_point(16'sd5, 16'sd5, 16'sd6, 16'sd4, 24'd1000);
    send_point(-16'sd3, 16'sd2, 16'sd3, -16'sd2, 24'd255);
    send_point(16'sd100, -16'sd100, 16'sd100, 16'sd200, 24'h00FF00);
    send_point(16'sd32767, 16'sd32767, 16'sd32766, 16'sd32767, 24'h7FFFFF);
    send_point(16'sd1, -16'sd1, 16'sd2, -16'sd1, 24'hAAAAAA);
    send_point(-16'sd1, 16'sd1, -16'sd2, 16'sd2, 24'h555555);
  endtask

  // Mix of full-range requests, short segments, distances near the length
  // and coinciding points.
  task automatic test_random(input int count, input int idle, input int stall);
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
    logic [DW-1:0]        distance;
    int                   dx;
    int                   dy;
    idle_pct = idle;
    stall_pct = stall;
    repeat (count) begin
      sx = CW'($urandom);
      sy = CW'($urandom);
      distance = DW'($urandom);
      case ($urandom_range(4))
        0: begin
          ex = CW'($urandom);
          ey = CW'($urandom);
        end
        1: begin
          dx = int'($urandom_range(64)) - 32;
          dy = int'($urandom_range(64)) - 32;
          ex = CW'(sx + dx);
          ey = CW'(sy + dy);
          distance = DW'($urandom_range(24'h3FFF));
        end
        2: begin
          sx = CW'(int'($urandom_range(2000)) - 1000);
          sy = CW'(int'($urandom_range(2000)) - 1000);
          ex = CW'(3 * (int'($urandom_range(200)) - 100));
          ey = CW'(4 * (int'($urandom_range(200)) - 100));
          distance = DW'($urandom_range(24'h1FFFF));
        end
        3: begin
          ex = sx;
          ey = sy;
          if ($urandom_range(1)) ex = CW'(sx + 1);
        end
        default: begin
          ex = CW'($urandom);
          ey = CW'($urandom);
          distance = DW'($urandom_range(24'hFF));
        end
      endcase
      send_point(sx, sy, ex, ey, distance);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(350, 0, 0);
    test_random(350, 67, 0);
    test_random(350, 0, 67);
    test_random(350, 29, 29);
    s_axis_tvalid <= 1'b0;
    wait (pending_points.size() == 0);
    repeat (40) @(posedge clk_i);
    $display("Sent %0d requests, checked %0d results (%0d saturated, %0d degenerate).",
             request_count, result_count, sat_count, degen_count);
    if (error_count == 0 && pending_points.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #5ms;
    $display("Timeout with %0d results outstanding", pending_points.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
hdl/posd_pkg.sv
hdl/posd_front.sv
hdl/posd_queue.sv
hdl/posd_back.sv
hdl/point_on_segment_at_distance.sv
hdl/posd_checker.sv
dv/point_on_segment_at_distance_test.sv
